[hdl/pkls_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkls_pkg
// shared constants and types of the per-key last-setter stack unit
// ----------------------------------------------------------------------------
package pkls_pkg;

	localparam int KEY_COUNT   = 123;
	localparam int STACK_DEPTH = 4;

	localparam int KEY_AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int POS_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam logic [1:0] STAT_APPLIED = 2'd0;
	localparam logic [1:0] STAT_RANGE   = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_NOMATCH = 2'd3;

	typedef struct packed {
		logic [6:0] key;
		logic [1:0] source_kind;
		logic [6:0] source_index;
		logic [6:0] level;
	} pkls_in_t;

	typedef struct packed {
		logic [6:0] key_level;
		logic [1:0] status;
	} pkls_out_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] index;
		logic [6:0] level;
	} setter_t;

	typedef struct packed {
		setter_t [STACK_DEPTH-1:0] entry;
		logic [CNT_W-1:0]          count;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		logic       wr;
		logic [6:0] level;
		logic [1:0] status;
	} edit_t;

endpackage

[hdl/pkls_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkls_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module pkls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/pkls_row_edit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkls_row_edit
// push or compacting removal on one key's setter row, newest level and status
// ----------------------------------------------------------------------------
module pkls_row_edit (
	input  pkls_pkg::row_t    row,
	input  pkls_pkg::pkls_in_t cmd,
	input  logic              found,
	input  logic [pkls_pkg::POS_W-1:0] pos,
	output pkls_pkg::row_t    new_row,
	output pkls_pkg::edit_t   edit
);
	import pkls_pkg::*;

	row_t       row_n;
	logic       wr;
	logic [1:0] status;
	logic [6:0] level;

	always_comb begin
		row_n  = row;
		wr     = 1'b0;
		status = STAT_APPLIED;
		if (cmd.level != 7'd0) begin
			if (int'(row.count) >= STACK_DEPTH) begin
				status = STAT_FULL;
			end else begin
				wr = 1'b1;
				for (int k = 0; k < STACK_DEPTH; k++) begin
					if (int'(row.count) == k) begin
						row_n.entry[k] = '{kind: cmd.source_kind, index: cmd.source_index,
							level: cmd.level};
					end
				end
				row_n.count = row.count + 1'b1;
			end
		end else if (found) begin
			wr = 1'b1;
			for (int k = 0; k < STACK_DEPTH - 1; k++) begin
				if (k >= int'(pos)) begin
					row_n.entry[k] = row.entry[k+1];
				end
			end
			row_n.count = row.count - 1'b1;
		end else begin
			status = STAT_NOMATCH;
		end

		level = 7'd0;
		for (int k = 0; k < STACK_DEPTH; k++) begin
			if (int'(row_n.count) == k + 1) begin
				level = row_n.entry[k].level;
			end
		end
	end

	assign new_row = row_n;
	assign edit    = '{wr: wr, level: level, status: status};

endmodule

[hdl/per_key_last_setter_stack_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_last_setter_stack_unit
// per-key stack of setters held in one row-wide ram: read, search, edit, write
// ----------------------------------------------------------------------------
// the result strobe follows acceptance through the read, search and write states
// and is registered; a new transaction is taken only once the last one has
// finished its ram read-modify-write
// busy is high from acceptance until the result strobe; results cannot be stalled
// reset clears the control state and the per-key valid bits at once, so every
// stack reads empty straight after reset with no clearing pass
module per_key_last_setter_stack_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pkls_pkg::pkls_in_t   item,
	output logic                 done,
	output pkls_pkg::pkls_out_t  result
);
	import pkls_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_FIND, ST_WRITE} state_t;

	state_t               state_q;
	logic                 done_q;
	pkls_out_t            result_q;
	logic [KEY_COUNT-1:0] valid_q;

	pkls_in_t             cmd_q;
	logic                 oor_q;
	logic [KEY_AW-1:0]    addr_q;
	logic [ROW_W-1:0]     rdata;
	row_t                 row_rd;
	row_t                 row_s1;
	logic                 found_s2;
	logic [POS_W-1:0]     pos_s2;
	logic                 found_c;
	logic [POS_W-1:0]     pos_c;
	row_t                 new_row;
	edit_t                edit;
	logic                 accept;
	logic                 wr_en;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;
	assign wr_en  = (state_q == ST_WRITE) && !oor_q && edit.wr;

	pkls_ram #(
		.WIDTH(ROW_W),
		.DEPTH(KEY_COUNT)
	) u_row_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_q),
		.wdata (new_row),
		.raddr (item.key[KEY_AW-1:0]),
		.rdata (rdata)
	);

	// unwritten or out of range rows read as empty
	always_comb begin
		row_rd = rdata;
		if (oor_q || !valid_q[addr_q]) begin
			row_rd.count = '0;
		end
	end

	// oldest matching setter below the count
	always_comb begin
		found_c = 1'b0;
		pos_c   = '0;
		for (int k = 0; k < STACK_DEPTH; k++) begin
			if (!found_c && (k < int'(row_s1.count)) &&
				(row_s1.entry[k].kind == cmd_q.source_kind) &&
				(row_s1.entry[k].index == cmd_q.source_index)) begin
				found_c = 1'b1;
				pos_c   = POS_W'(k);
			end
		end
	end

	pkls_row_edit u_row_edit (
		.row     (row_s1),
		.cmd     (cmd_q),
		.found   (found_s2),
		.pos     (pos_s2),
		.new_row (new_row),
		.edit    (edit)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= item;
			oor_q  <= (int'(item.key) >= KEY_COUNT);
			addr_q <= item.key[KEY_AW-1:0];
		end
		if (state_q == ST_READ) begin
			row_s1 <= row_rd;
		end
		if (state_q == ST_FIND) begin
			found_s2 <= found_c;
			pos_s2   <= pos_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
			valid_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_FIND;
				end
				ST_FIND: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (oor_q) begin
						result_q <= '{key_level: 7'd0, status: STAT_RANGE};
					end else begin
						result_q <= '{key_level: edit.level, status: edit.status};
					end
					if (wr_en) begin
						valid_q[addr_q] <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[tb/pkls_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkls_checker
// watches the command and result channels of the per-key last-setter stack
// unit, keeps its own copy of every key's setter stack, predicts the level and
// status of each accepted transaction and compares them with the results
// ----------------------------------------------------------------------------
module pkls_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  pkls_pkg::pkls_in_t  item,
	input  logic                done,
	input  pkls_pkg::pkls_out_t result,
	output int                  errors,
	output int                  pending,
	output int                  seen_full,
	output int                  seen_nomatch,
	output int                  seen_range
);
	import pkls_pkg::*;

	setter_t   stack_mem [KEY_COUNT][STACK_DEPTH];
	int        stack_fill [KEY_COUNT];
	pkls_out_t expected_levels [$];

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t ns: %s", $time, msg);
	endtask

	function automatic pkls_out_t predict_key_level(input pkls_in_t t);
		pkls_out_t r;
		setter_t   entry;
		int        n;
		int        hit;
		int        k;
		r.key_level = '0;
		r.status    = STAT_APPLIED;
		if (t.key >= KEY_COUNT) begin
			r.status = STAT_RANGE;
			return r;
		end
		n = stack_fill[t.key];
		if (t.level != '0) begin
			if (n >= STACK_DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				entry.kind  = t.source_kind;
				entry.index = t.source_index;
				entry.level = t.level;
				stack_mem[t.key][n] = entry;
				n++;
			end
		end else begin
			hit = -1;
			for (k = 0; k < n; k++)
				if (hit < 0 && stack_mem[t.key][k].kind == t.source_kind &&
				    stack_mem[t.key][k].index == t.source_index)
					hit = k;
			if (hit < 0) begin
				r.status = STAT_NOMATCH;
			end else begin
				// oldest match goes, newer setters move down
				for (k = hit; k < n - 1; k++)
					stack_mem[t.key][k] = stack_mem[t.key][k + 1];
				n--;
			end
		end
		stack_fill[t.key] = n;
		if (n > 0)
			r.key_level = stack_mem[t.key][n - 1].level;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pkls_out_t want;
		int        k;
		if (!arst_n) begin
			for (k = 0; k < KEY_COUNT; k++)
				stack_fill[k] = 0;
			expected_levels.delete();
			errors       = 0;
			pending      = 0;
			seen_full    = 0;
			seen_nomatch = 0;
			seen_range   = 0;
		end else begin
			if (done) begin
				if (expected_levels.size() == 0) begin
					report_mismatch($sformatf("result with no transaction waiting: level %0d status %0d",
						result.key_level, result.status));
				end else begin
					want = expected_levels.pop_front();
					if (result.key_level !== want.key_level)
						report_mismatch($sformatf("key_level %0d, expected %0d",
							result.key_level, want.key_level));
					if (result.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							result.status, want.status));
				end
			end
			if (start && !busy) begin
				want = predict_key_level(item);
				expected_levels.push_back(want);
				case (want.status)
					STAT_FULL:    seen_full++;
					STAT_NOMATCH: seen_nomatch++;
					STAT_RANGE:   seen_range++;
					default: ;
				endcase
			end
			pending = expected_levels.size();
		end
	end

endmodule

[tb/per_key_last_setter_stack_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_last_setter_stack_unit_tb
// drives directed and random key events into the stack unit under varying
// sender idling; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module per_key_last_setter_stack_unit_tb;
	import pkls_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	logic      done;
	pkls_in_t  item;
	pkls_out_t result;

	int errors;
	int pending;
	int seen_full;
	int seen_nomatch;
	int seen_range;
	int sent;
	int idle_pct;
	int idle_mix [3] = '{0, 51, 8};
	int hot_keys [6] = '{0, 1, 61, 64, 121, 122};
	logic [1:0] pool_kind  [8];
	logic [6:0] pool_index [8];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	per_key_last_setter_stack_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	pkls_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.done         (done),
		.result       (result),
		.errors       (errors),
		.pending      (pending),
		.seen_full    (seen_full),
		.seen_nomatch (seen_nomatch),
		.seen_range   (seen_range)
	);

	function automatic pkls_in_t key_event(input int key, input int kind, input int index,
		input int level);
		pkls_in_t t;
		t.key          = key[6:0];
		t.source_kind  = kind[1:0];
		t.source_index = index[6:0];
		t.level        = level[6:0];
		return t;
	endfunction

	function automatic pkls_in_t random_key_event();
		pkls_in_t t;
		int       pick;
		t = key_event($urandom_range(127), $urandom_range(3), $urandom_range(127),
			$urandom_range(127));
		// mostly well-formed traffic on a few busy keys, the rest noise
		if ($urandom_range(99) >= 8) begin
			if ($urandom_range(99) < 80)
				t.key = 7'(hot_keys[$urandom_range(5)]);
			else
				t.key = 7'($urandom_range(KEY_COUNT - 1));
			if ($urandom_range(99) < 90) begin
				pick = $urandom_range(7);
				t.source_kind  = pool_kind[pick];
				t.source_index = pool_index[pick];
			end
			t.level = ($urandom_range(99) < 50) ? 7'd0 : 7'($urandom_range(127, 1));
		end else if ($urandom_range(1) == 0) begin
			t.key = 7'($urandom_range(127, KEY_COUNT));
		end
		return t;
	endfunction

	task automatic issue(input pkls_in_t t);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		item  <= t;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		item     = '0;
		sent     = 0;
		idle_pct = 0;
		for (int k = 0; k < 8; k++) begin
			pool_kind[k]  = 2'(k % 4);
			pool_index[k] = 7'($urandom_range(127));
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// out of range, empty release, fill to full, release from the middle
		issue(key_event(127, 3, 127, 127));
		issue(key_event(KEY_COUNT, 0, 0, 0));
		issue(key_event(0, 0, 0, 0));
		issue(key_event(0, 0, 0, 1));
		issue(key_event(0, 1, 127, 127));
		issue(key_event(0, 2, 5, 64));
		issue(key_event(0, 3, 5, 33));
		issue(key_event(0, 0, 9, 10));
		issue(key_event(0, 3, 6, 0));
		issue(key_event(0, 1, 127, 0));
		issue(key_event(0, 3, 5, 0));
		// duplicate setters on the top key
		issue(key_event(KEY_COUNT - 1, 2, 42, 20));
		issue(key_event(KEY_COUNT - 1, 2, 42, 21));
		issue(key_event(KEY_COUNT - 1, 1, 3, 100));
		issue(key_event(KEY_COUNT - 1, 2, 42, 0));
		issue(key_event(KEY_COUNT - 1, 1, 3, 0));
		issue(key_event(KEY_COUNT - 1, 2, 42, 0));
		issue(key_event(KEY_COUNT - 1, 2, 42, 0));
		issue(key_event(0, 0, 0, 0));
		issue(key_event(0, 2, 5, 0));
		settle();

		for (int p = 0; p < 3; p++) begin
			idle_pct = idle_mix[p];
			for (int i = 0; i < 600; i++) begin
				issue(random_key_event());
				if (p == 1 && i == 300)
					settle();
			end
			settle();
		end

		$display("%0d transactions sent under sender idling of 0, 51 and 8 per cent", sent);
		$display("%0d dropped on full stacks, %0d unmatched releases, %0d keys out of range",
			seen_full, seen_nomatch, seen_range);
		if (errors == 0)
			$display("[per_key_last_setter_stack_unit] OK");
		else
			$display("[per_key_last_setter_stack_unit] ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[per_key_last_setter_stack_unit] ERROR");
		$finish;
	end

endmodule
